@@ design/assert_macros.svh @@
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)

`define ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

@@ design/glcm_pkg.sv @@
// shared types, codes and widths of the co-occurrence accumulator
package glcm_pkg;

    localparam int OP_W        = 2;
    localparam int PIXEL_W     = 8;
    localparam int LEVEL_W     = 8;
    localparam int BIN_COUNT_W = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int IMG_WIDTH_W = 11;

    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_PIXEL = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_TOP_LEVEL   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIRECTION   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH = 2'd2;

    typedef enum logic [1:0] {
        DIR_RIGHT   = 2'd0,
        DIR_DIAG45  = 2'd1,
        DIR_DOWN    = 2'd2,
        DIR_DIAG135 = 2'd3
    } t_dir;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PX_MUL,
        ST_PX_QUANT,
        ST_PX_PAIR,
        ST_PX_BUMP,
        ST_RD_ADDR,
        ST_RD_DATA
    } t_state;

    typedef struct packed {
        logic load_item;
        logic clear_start;
        logic clear_step;
        logic mul;
        logic quant;
        logic row_next;
        logic pair;
        logic commit;
        logic read_sel;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic out_free;
    } t_status;

endpackage

@@ design/glcm_in_if.sv @@
// request channel: op and its operands
interface glcm_in_if;
    logic                              valid;
    logic                              ready;
    logic [glcm_pkg::OP_W-1:0]         op;
    logic [glcm_pkg::PIXEL_W-1:0]      pixel;
    logic [glcm_pkg::LEVEL_W-1:0]      bin_row;
    logic [glcm_pkg::LEVEL_W-1:0]      bin_col;

    modport source (output valid, output op, output pixel, output bin_row, output bin_col,
                    input ready);
    modport sink (input valid, input op, input pixel, input bin_row, input bin_col,
                  output ready);
endinterface

@@ design/glcm_out_if.sv @@
// result channel: bin count and range flag
interface glcm_out_if;
    logic                                valid;
    logic                                ready;
    logic [glcm_pkg::BIN_COUNT_W-1:0]    bin_count;
    logic                                out_of_range;

    modport source (output valid, output bin_count, output out_of_range, input ready);
    modport sink (input valid, input bin_count, input out_of_range, output ready);
endinterface

@@ design/glcm_ram.sv @@
// generic single write, single read ram with registered read data
module glcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/glcm_ctrl.sv @@
// sequencer for clear, pixel and read requests
`include "assert_macros.svh"

module glcm_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_req_valid,
    input  logic [glcm_pkg::OP_W-1:0] i_req_op,
    output logic                      o_req_ready,
    input  glcm_pkg::t_status         i_status,
    output glcm_pkg::t_cmd            o_cmd
);

    glcm_pkg::t_state r_state;
    glcm_pkg::t_state n_state;
    logic             accept;

    assign accept = i_req_valid && o_req_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= glcm_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            glcm_pkg::ST_CLEAR: begin
                if (i_status.clear_last) begin
                    n_state = glcm_pkg::ST_IDLE;
                end
            end
            glcm_pkg::ST_IDLE: begin
                if (i_req_valid) begin
                    unique case (i_req_op)
                        glcm_pkg::OP_CLEAR: n_state = glcm_pkg::ST_CLEAR;
                        glcm_pkg::OP_PIXEL: n_state = glcm_pkg::ST_PX_MUL;
                        glcm_pkg::OP_READ:  n_state = glcm_pkg::ST_RD_ADDR;
                        default:            n_state = glcm_pkg::ST_IDLE;
                    endcase
                end
            end
            glcm_pkg::ST_PX_MUL:   n_state = glcm_pkg::ST_PX_QUANT;
            glcm_pkg::ST_PX_QUANT: n_state = glcm_pkg::ST_PX_PAIR;
            glcm_pkg::ST_PX_PAIR:  n_state = glcm_pkg::ST_PX_BUMP;
            glcm_pkg::ST_PX_BUMP:  n_state = glcm_pkg::ST_IDLE;
            glcm_pkg::ST_RD_ADDR:  n_state = glcm_pkg::ST_RD_DATA;
            glcm_pkg::ST_RD_DATA: begin
                if (i_status.out_free) begin
                    n_state = glcm_pkg::ST_IDLE;
                end
            end
            default: n_state = glcm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            glcm_pkg::ST_CLEAR: begin
                o_cmd.clear_step = 1'b1;
            end
            glcm_pkg::ST_IDLE: begin
                o_req_ready       = 1'b1;
                o_cmd.load_item   = accept;
                o_cmd.clear_start = accept && (i_req_op == glcm_pkg::OP_CLEAR);
            end
            glcm_pkg::ST_PX_MUL: begin
                o_cmd.mul = 1'b1;
            end
            glcm_pkg::ST_PX_QUANT: begin
                o_cmd.quant    = 1'b1;
                o_cmd.row_next = 1'b1;
            end
            glcm_pkg::ST_PX_PAIR: begin
                o_cmd.pair = 1'b1;
            end
            glcm_pkg::ST_PX_BUMP: begin
                o_cmd.commit = 1'b1;
            end
            glcm_pkg::ST_RD_ADDR: begin
                o_cmd.read_sel = 1'b1;
            end
            glcm_pkg::ST_RD_DATA: begin
                o_cmd.read_sel = 1'b1;
                o_cmd.out_load = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    `ASSERT_CLK(a_pixel_starts, i_clk, i_rst_n, (accept && (i_req_op == glcm_pkg::OP_PIXEL)) |=> (r_state == glcm_pkg::ST_PX_MUL), "pixel request did not start the pixel sequence")
    `ASSERT_CLK(a_commit_ends, i_clk, i_rst_n, o_cmd.commit |=> (r_state == glcm_pkg::ST_IDLE), "pixel commit not followed by idle")
    `ASSERT_NEVER(a_clear_vs_commit, i_clk, i_rst_n, o_cmd.clear_step && (o_cmd.commit || o_cmd.out_load), "table clear overlaps another table access")

endmodule

@@ design/glcm_dp.sv @@
// datapath: config registers, quantizer, row line, pair table and result register
`include "assert_macros.svh"

module glcm_dp #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_LEVELS = 256,
    parameter int COUNT_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [glcm_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [glcm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [glcm_pkg::PIXEL_W-1:0]        i_pixel,
    input  logic [glcm_pkg::LEVEL_W-1:0]        i_bin_row,
    input  logic [glcm_pkg::LEVEL_W-1:0]        i_bin_col,
    input  glcm_pkg::t_cmd                      i_cmd,
    output glcm_pkg::t_status                   o_status,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [glcm_pkg::BIN_COUNT_W-1:0]    o_bin_count,
    output logic                                o_out_of_range
);

    localparam int LW        = $clog2(MAX_LEVELS);
    localparam int TBL_AW    = 2 * LW;
    localparam int TBL_DEPTH = 1 << TBL_AW;
    localparam int XW        = $clog2(MAX_WIDTH);
    localparam int WW        = ($clog2(MAX_WIDTH + 1) > glcm_pkg::IMG_WIDTH_W) ?
                               $clog2(MAX_WIDTH + 1) : glcm_pkg::IMG_WIDTH_W;
    localparam int PROD_W    = glcm_pkg::PIXEL_W + glcm_pkg::LEVEL_W;
    localparam logic [glcm_pkg::LEVEL_W-1:0] LVL_MAX = glcm_pkg::LEVEL_W'(MAX_LEVELS - 1);
    localparam logic [WW-1:0] WIDTH_MAX = WW'(MAX_WIDTH);
    localparam logic [glcm_pkg::IMG_WIDTH_W-1:0] WIDTH_RST = glcm_pkg::IMG_WIDTH_W'(1024);
    localparam logic [31:0] OUT_MAX = 32'h0000_FFFF;

    // floor(m / 255) for m below 65280
    function automatic logic [glcm_pkg::LEVEL_W-1:0] quantize(input logic [PROD_W-1:0] m);
        logic [PROD_W:0] t;
        t = {1'b0, m} + {9'd0, m[PROD_W-1:8]} + (PROD_W + 1)'(1);
        return t[15:8];
    endfunction

    logic [glcm_pkg::LEVEL_W-1:0]     r_top_level;
    glcm_pkg::t_dir                   r_direction;
    logic [glcm_pkg::IMG_WIDTH_W-1:0] r_image_width;

    logic [glcm_pkg::PIXEL_W-1:0]     r_pixel;
    logic [glcm_pkg::LEVEL_W-1:0]     r_bin_row;
    logic [glcm_pkg::LEVEL_W-1:0]     r_bin_col;
    logic [PROD_W-1:0]                r_prod;
    logic [LW-1:0]                    r_q;
    logic [LW-1:0]                    r_above;
    logic [TBL_AW-1:0]                r_pair_addr;
    logic                             r_bump;

    logic [LW-1:0]                    r_left;
    logic [LW-1:0]                    r_above_left;
    logic [XW-1:0]                    r_col;
    logic                             r_first_row;
    logic [TBL_AW-1:0]                r_clr_addr;

    logic                             r_out_valid;
    logic [glcm_pkg::BIN_COUNT_W-1:0] r_out_count;
    logic                             r_out_oor;

    logic [glcm_pkg::LEVEL_W-1:0]     lvl;
    logic [glcm_pkg::LEVEL_W-1:0]     q_full;
    logic [WW-1:0]                    eff_width;
    logic [WW-1:0]                    col_next;
    logic                             last;
    logic [LW-1:0]                    pair_first;
    logic                             pair_bump;

    logic [XW-1:0]                    row_raddr;
    logic [LW-1:0]                    row_rdata;
    logic                             tbl_we;
    logic [TBL_AW-1:0]                tbl_waddr;
    logic [COUNT_BITS-1:0]            tbl_wdata;
    logic [TBL_AW-1:0]                tbl_raddr;
    logic [COUNT_BITS-1:0]            tbl_rdata;
    logic [COUNT_BITS-1:0]            tbl_inc;
    logic [31:0]                      tbl_wide;
    logic                             rd_oor;
    logic [glcm_pkg::BIN_COUNT_W-1:0] rd_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_level   <= 8'd255;
            r_direction   <= glcm_pkg::DIR_RIGHT;
            r_image_width <= WIDTH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                glcm_pkg::CFG_TOP_LEVEL:
                    r_top_level <= i_cfg_data[glcm_pkg::LEVEL_W-1:0];
                glcm_pkg::CFG_DIRECTION:
                    r_direction <= glcm_pkg::t_dir'(i_cfg_data[1:0]);
                glcm_pkg::CFG_IMAGE_WIDTH:
                    r_image_width <= i_cfg_data[glcm_pkg::IMG_WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    assign lvl = (r_top_level > LVL_MAX) ? LVL_MAX : r_top_level;

    always_comb begin
        eff_width = WW'(r_image_width);
        if (eff_width == '0) begin
            eff_width = WW'(1);
        end else if (eff_width > WIDTH_MAX) begin
            eff_width = WIDTH_MAX;
        end
    end

    assign col_next = WW'(r_col) + WW'(1);
    assign last     = (col_next >= eff_width);

    always_comb begin
        pair_first = r_left;
        pair_bump  = 1'b0;
        case (r_direction)
            glcm_pkg::DIR_RIGHT: begin
                pair_first = r_left;
                pair_bump  = (r_col != '0);
            end
            glcm_pkg::DIR_DIAG45: begin
                pair_first = r_above_left;
                pair_bump  = !r_first_row && (r_col != '0);
            end
            glcm_pkg::DIR_DOWN: begin
                pair_first = r_above;
                pair_bump  = !r_first_row;
            end
            default: begin
                pair_first = row_rdata;
                pair_bump  = !r_first_row && !last;
            end
        endcase
    end

    assign q_full = quantize(r_prod);

    // pixel pipeline registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_pixel   <= i_pixel;
            r_bin_row <= i_bin_row;
            r_bin_col <= i_bin_col;
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_pixel) * PROD_W'(lvl);
        end
        if (i_cmd.quant) begin
            r_q     <= q_full[LW-1:0];
            r_above <= row_rdata;
        end
        if (i_cmd.pair) begin
            r_pair_addr <= {pair_first, r_q};
            r_bump      <= pair_bump;
        end
    end

    // frame position and clear sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_start) begin
            r_left       <= '0;
            r_above_left <= '0;
            r_col        <= '0;
            r_first_row  <= 1'b1;
            r_clr_addr   <= '0;
        end else begin
            if (i_cmd.clear_step) begin
                r_clr_addr <= r_clr_addr + TBL_AW'(1);
            end
            if (i_cmd.commit) begin
                r_left       <= r_q;
                r_above_left <= r_above;
                if (last) begin
                    r_col       <= '0;
                    r_first_row <= 1'b0;
                end else begin
                    r_col <= col_next[XW-1:0];
                end
            end
        end
    end

    assign row_raddr = i_cmd.row_next ? (r_col + XW'(1)) : r_col;

    glcm_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_WIDTH)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit),
        .i_waddr (r_col),
        .i_wdata (r_q),
        .i_raddr (row_raddr),
        .o_rdata (row_rdata)
    );

    assign tbl_inc   = (&tbl_rdata) ? tbl_rdata : (tbl_rdata + COUNT_BITS'(1));
    assign tbl_we    = i_cmd.clear_step || (i_cmd.commit && r_bump);
    assign tbl_waddr = i_cmd.clear_step ? r_clr_addr : r_pair_addr;
    assign tbl_wdata = i_cmd.clear_step ? '0 : tbl_inc;
    assign tbl_raddr = i_cmd.read_sel ? {r_bin_row[LW-1:0], r_bin_col[LW-1:0]}
                                      : {pair_first, r_q};

    glcm_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (TBL_DEPTH)
    ) u_tbl_ram (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    assign tbl_wide = 32'(tbl_rdata);
    assign rd_oor   = (r_bin_row > lvl) || (r_bin_col > lvl);
    assign rd_count = rd_oor ? '0 :
                      ((tbl_wide > OUT_MAX) ? OUT_MAX[glcm_pkg::BIN_COUNT_W-1:0]
                                            : tbl_wide[glcm_pkg::BIN_COUNT_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_count <= rd_count;
            r_out_oor   <= rd_oor;
        end
    end

    assign o_status.clear_last = &r_clr_addr;
    assign o_status.out_free   = !r_out_valid || i_out_ready;
    assign o_out_valid         = r_out_valid;
    assign o_bin_count         = r_out_count;
    assign o_out_of_range      = r_out_oor;

    `ASSERT_CLK(a_row_wrap, i_clk, i_rst_n, (i_cmd.commit && last) |=> ((r_col == '0) && !r_first_row), "row end did not restart the column")
    `ASSERT_CLK(a_out_no_overwrite, i_clk, i_rst_n, i_cmd.out_load |-> (!r_out_valid || i_out_ready), "result register overwritten before it was taken")
    `ASSERT_CLK(a_oor_zero, i_clk, i_rst_n, (r_out_valid && r_out_oor) |-> (r_out_count == '0), "out of range bin with nonzero count")

endmodule

@@ design/glcm_accumulator.sv @@
// top level of the gray level co-occurrence accumulator
//
// channel   dir  handshake          payload
// i_req     in   valid / ready      op, pixel, bin_row, bin_col
// o_rsp     out  valid / ready      bin_count, out_of_range
// i_cfg_*   in   write enable only  index, data
//
// pixel request: accept, multiply, quantize, pair lookup, table update, in that order
// read request: accept, table read, output load; waits if an earlier result is unread
// clear request and reset: sweeps 2**(2*clog2(MAX_LEVELS)) entries (65536 by default)
//   through the single write port of the table memory; no request taken meanwhile
// config writes are taken in any cycle
module glcm_accumulator #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_LEVELS = 256,
    parameter int COUNT_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [glcm_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [glcm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    glcm_in_if.sink                          i_req,
    glcm_out_if.source                       o_rsp
);

    glcm_pkg::t_cmd    cmd;
    glcm_pkg::t_status status;
    logic              req_ready;

    assign i_req.ready = req_ready;

    glcm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_op    (i_req.op),
        .o_req_ready (req_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    glcm_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_LEVELS (MAX_LEVELS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_pixel        (i_req.pixel),
        .i_bin_row      (i_req.bin_row),
        .i_bin_col      (i_req.bin_col),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_out_ready    (o_rsp.ready),
        .o_out_valid    (o_rsp.valid),
        .o_bin_count    (o_rsp.bin_count),
        .o_out_of_range (o_rsp.out_of_range)
    );

endmodule

@@ tb/tb_glcm_accumulator.sv @@
// testbench of the co-occurrence accumulator: pixel streams and bin reads against a local model
module tb_glcm_accumulator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [glcm_pkg::OP_W-1:0] OP_IGNORED = 2'd3;
    localparam int ROW_MAX = 1024;
    localparam logic [glcm_pkg::BIN_COUNT_W-1:0] COUNT_TOP = '1;

    typedef struct packed {
        logic [glcm_pkg::OP_W-1:0]    op;
        logic [glcm_pkg::PIXEL_W-1:0] pixel;
        logic [glcm_pkg::LEVEL_W-1:0] bin_row;
        logic [glcm_pkg::LEVEL_W-1:0] bin_col;
    } t_req;

    typedef struct packed {
        logic [glcm_pkg::BIN_COUNT_W-1:0] bin_count;
        logic                             out_of_range;
    } t_bin_rsp;

    typedef enum {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_PERIODIC} t_rdy_mode;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             cfg_we;
    logic [glcm_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [glcm_pkg::CFG_DATA_W-1:0]  cfg_data;

    glcm_in_if  req_ch();
    glcm_out_if rsp_ch();

    glcm_accumulator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    // model state
    logic [glcm_pkg::BIN_COUNT_W-1:0] pair_tab [int];
    logic [glcm_pkg::LEVEL_W-1:0]     row_q [0:ROW_MAX-1] = '{default: '0};
    logic [glcm_pkg::LEVEL_W-1:0]     left_q = '0;
    logic [glcm_pkg::LEVEL_W-1:0]     upleft_q = '0;
    int                               col_pos = 0;
    bit                               first_row = 1'b1;
    logic [glcm_pkg::LEVEL_W-1:0]     lvl_reg = 8'd255;
    glcm_pkg::t_dir                   dir_reg = glcm_pkg::DIR_RIGHT;
    logic [glcm_pkg::IMG_WIDTH_W-1:0] width_reg = 11'd1024;

    t_bin_rsp bin_expect_q[$];
    t_req     req_pending_q[$];

    int n_errors = 0;
    int n_checked = 0;
    int n_pixels = 0;
    int n_reads = 0;
    int n_clears = 0;
    int n_ignored = 0;
    int n_settings = 0;

    int gen_level = 255;
    int recent_q[$];
    int last_px = 128;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int clamp_width(int w);
        if (w < 1) return 1;
        if (w > ROW_MAX) return ROW_MAX;
        return w;
    endfunction

    function automatic void bump_pair(logic [glcm_pkg::LEVEL_W-1:0] a,
                                      logic [glcm_pkg::LEVEL_W-1:0] b);
        int key = int'({a, b});
        if (!pair_tab.exists(key)) pair_tab[key] = '0;
        if (pair_tab[key] != COUNT_TOP) pair_tab[key] = pair_tab[key] + 1'b1;
    endfunction

    function automatic void count_pixel(logic [glcm_pkg::PIXEL_W-1:0] p);
        int                           w;
        int                           x;
        logic [glcm_pkg::LEVEL_W-1:0] q;
        logic [glcm_pkg::LEVEL_W-1:0] up;
        logic [glcm_pkg::LEVEL_W-1:0] upright;
        bit                           last;
        w = clamp_width(int'(width_reg));
        x = col_pos;
        q = glcm_pkg::LEVEL_W'((int'(p) * int'(lvl_reg)) / 255);
        up = row_q[x];
        upright = (x + 1 < ROW_MAX) ? row_q[x + 1] : '0;
        last = (x + 1 >= w);
        case (dir_reg)
            glcm_pkg::DIR_RIGHT:  if (x > 0) bump_pair(left_q, q);
            glcm_pkg::DIR_DIAG45: if (!first_row && x > 0) bump_pair(upleft_q, q);
            glcm_pkg::DIR_DOWN:   if (!first_row) bump_pair(up, q);
            default:              if (!first_row && !last) bump_pair(upright, q);
        endcase
        upleft_q = up;
        left_q = q;
        row_q[x] = q;
        if (last) begin
            col_pos = 0;
            first_row = 1'b0;
        end else begin
            col_pos = x + 1;
        end
    endfunction

    function automatic void apply_request(t_req r);
        t_bin_rsp e;
        int       key;
        case (r.op)
            glcm_pkg::OP_CLEAR: begin
                pair_tab.delete();
                left_q = '0;
                upleft_q = '0;
                col_pos = 0;
                first_row = 1'b1;
                n_clears++;
            end
            glcm_pkg::OP_PIXEL: begin
                count_pixel(r.pixel);
                n_pixels++;
            end
            glcm_pkg::OP_READ: begin
                key = int'({r.bin_row, r.bin_col});
                if (r.bin_row > lvl_reg || r.bin_col > lvl_reg) begin
                    e.bin_count = '0;
                    e.out_of_range = 1'b1;
                end else begin
                    e.bin_count = pair_tab.exists(key) ? pair_tab[key] : '0;
                    e.out_of_range = 1'b0;
                end
                bin_expect_q.push_back(e);
                n_reads++;
            end
            default: n_ignored++;
        endcase
    endfunction

    // request driver
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge i_clk) begin
        t_req nxt;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                apply_request({req_ch.op, req_ch.pixel, req_ch.bin_row, req_ch.bin_col});
            end
            if (req_ch.valid && !req_ch.ready) begin
                // hold until taken
            end else if (gap_left > 0) begin
                gap_left--;
                req_ch.valid <= 1'b0;
            end else if (req_pending_q.size() > 0) begin
                nxt = req_pending_q.pop_front();
                req_ch.valid <= 1'b1;
                req_ch.op <= nxt.op;
                req_ch.pixel <= nxt.pixel;
                req_ch.bin_row <= nxt.bin_row;
                req_ch.bin_col <= nxt.bin_col;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                             : $urandom_range(1, 20);
                    gap_left = $urandom_range(1, 9);
                end
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // result monitor
    t_rdy_mode rdy_mode = RDY_ALWAYS;
    int        mode_left = 0;
    int        tick = 0;

    always @(posedge i_clk) begin
        t_bin_rsp exp_rsp;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (bin_expect_q.size() == 0) begin
                    $error("unexpected result: bin_count %0d out_of_range %0b",
                           rsp_ch.bin_count, rsp_ch.out_of_range);
                    n_errors++;
                end else begin
                    exp_rsp = bin_expect_q.pop_front();
                    n_checked++;
                    if (rsp_ch.bin_count !== exp_rsp.bin_count) begin
                        $error("bin_count: expected %0d, actual %0d",
                               exp_rsp.bin_count, rsp_ch.bin_count);
                        n_errors++;
                    end
                    if (rsp_ch.out_of_range !== exp_rsp.out_of_range) begin
                        $error("out_of_range: expected %0b, actual %0b",
                               exp_rsp.out_of_range, rsp_ch.out_of_range);
                        n_errors++;
                    end
                end
            end
            if (mode_left == 0) begin
                rdy_mode = t_rdy_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end else begin
                mode_left--;
            end
            tick++;
            case (rdy_mode)
                RDY_ALWAYS: rsp_ch.ready <= 1'b1;
                RDY_COIN:   rsp_ch.ready <= 1'($urandom_range(0, 1));
                RDY_SPARSE: rsp_ch.ready <= ($urandom_range(0, 4) == 0);
                default:    rsp_ch.ready <= ((tick % 5) != 0);
            endcase
        end
    end

    function automatic void push_req(logic [glcm_pkg::OP_W-1:0] op, int p, int r, int c);
        t_req item;
        item.op = op;
        item.pixel = glcm_pkg::PIXEL_W'(p);
        item.bin_row = glcm_pkg::LEVEL_W'(r);
        item.bin_col = glcm_pkg::LEVEL_W'(c);
        req_pending_q.push_back(item);
    endfunction

    function automatic void push_pixel(int p);
        push_req(glcm_pkg::OP_PIXEL, p, $urandom_range(0, 255), $urandom_range(0, 255));
        recent_q.push_back((p * gen_level) / 255);
        if (recent_q.size() > 8) void'(recent_q.pop_front());
    endfunction

    function automatic void push_read(int r, int c);
        push_req(glcm_pkg::OP_READ, $urandom_range(0, 255), r, c);
    endfunction

    task automatic wait_idle();
        do @(negedge i_clk);
        while (req_pending_q.size() != 0 || req_ch.valid || !req_ch.ready ||
               bin_expect_q.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_phase(int lvl, glcm_pkg::t_dir dir, int width);
        bit widen;
        wait_idle();
        widen = clamp_width(width) > clamp_width(int'(width_reg));
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= glcm_pkg::CFG_TOP_LEVEL;
        cfg_data <= glcm_pkg::CFG_DATA_W'(lvl);
        @(posedge i_clk);
        cfg_index <= glcm_pkg::CFG_DIRECTION;
        cfg_data <= glcm_pkg::CFG_DATA_W'(dir);
        @(posedge i_clk);
        cfg_index <= glcm_pkg::CFG_IMAGE_WIDTH;
        cfg_data <= glcm_pkg::CFG_DATA_W'(width);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        lvl_reg = glcm_pkg::LEVEL_W'(lvl);
        dir_reg = dir;
        width_reg = glcm_pkg::IMG_WIDTH_W'(width);
        gen_level = lvl;
        recent_q.delete();
        n_settings++;
        @(negedge i_clk);
        // a wider row must not pick up row entries never written
        if (widen) push_req(glcm_pkg::OP_CLEAR, 0, 0, 0);
    endtask

    task automatic stream_phase(int n_items, bit with_clear);
        int pick;
        int sel;
        int px;
        int clear_at;
        clear_at = with_clear ? $urandom_range(n_items / 4, (3 * n_items) / 4) : -1;
        for (int i = 0; i < n_items; i++) begin
            if (i == clear_at) push_req(glcm_pkg::OP_CLEAR, $urandom_range(0, 255),
                                        $urandom_range(0, 255), $urandom_range(0, 255));
            pick = $urandom_range(0, 99);
            if (pick < 3) push_req(OP_IGNORED, $urandom_range(0, 255),
                                   $urandom_range(0, 255), $urandom_range(0, 255));
            if (pick < 30) begin
                sel = $urandom_range(0, 9);
                if (sel < 6 && recent_q.size() > 0) begin
                    push_read(recent_q[$urandom_range(0, recent_q.size() - 1)],
                              recent_q[$urandom_range(0, recent_q.size() - 1)]);
                end else if (sel < 9) begin
                    push_read($urandom_range(0, gen_level), $urandom_range(0, gen_level));
                end else begin
                    push_read($urandom_range(0, 255), $urandom_range(0, 255));
                end
            end else begin
                sel = $urandom_range(0, 9);
                if (sel < 2) begin
                    px = $urandom_range(0, 1) ? 255 : 0;
                end else if (sel < 6) begin
                    px = last_px + int'($urandom_range(0, 16)) - 8;
                    if (px < 0) px = 0;
                    if (px > 255) px = 255;
                end else begin
                    px = $urandom_range(0, 255);
                end
                last_px = px;
                push_pixel(px);
            end
        end
        push_read($urandom_range(0, gen_level), $urandom_range(0, gen_level));
    endtask

    initial begin
        req_ch.valid = 1'b0;
        req_ch.op = glcm_pkg::OP_CLEAR;
        req_ch.pixel = '0;
        req_ch.bin_row = '0;
        req_ch.bin_col = '0;
        rsp_ch.ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = glcm_pkg::CFG_TOP_LEVEL;
        cfg_data = '0;
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // full scale levels, horizontal pairs, ignored op
        set_phase(255, glcm_pkg::DIR_RIGHT, 4);
        push_pixel(0);
        push_pixel(255);
        push_pixel(255);
        push_pixel(0);
        push_read(0, 255);
        push_read(255, 255);
        push_read(255, 0);
        push_read(0, 0);
        push_req(OP_IGNORED, 8'hA5, 8'h5A, 8'hFF);
        push_read(255, 255);

        // single level, 135 degree pairs, reads past the top level
        set_phase(0, glcm_pkg::DIR_DIAG135, 3);
        push_pixel(255);
        push_pixel(128);
        push_pixel(0);
        push_pixel(255);
        push_pixel(0);
        push_pixel(255);
        push_read(0, 0);
        push_read(1, 0);
        push_read(0, 255);
        push_read(255, 255);

        set_phase(7, glcm_pkg::DIR_DOWN, 0);
        stream_phase(120, 1'b0);
        set_phase(15, glcm_pkg::DIR_DOWN, 5);
        stream_phase(250, 1'b0);
        set_phase(3, glcm_pkg::DIR_RIGHT, 2);
        stream_phase(250, 1'b1);
        set_phase(255, glcm_pkg::DIR_DIAG135, 9);
        stream_phase(250, 1'b0);
        set_phase(31, glcm_pkg::DIR_DIAG45, 6);
        stream_phase(250, 1'b0);
        set_phase(1, glcm_pkg::DIR_DIAG45, 3);
        stream_phase(200, 1'b0);
        set_phase(100, glcm_pkg::DIR_DIAG135, 3);
        stream_phase(200, 1'b0);

        // widest row, oversized width setting, reads past the top level
        set_phase(128, glcm_pkg::DIR_RIGHT, 2047);
        for (int i = 0; i < 40; i++) push_pixel($urandom_range(0, 1));
        push_read(0, 0);
        for (int i = 0; i < 3; i++) push_pixel(0);
        push_read(0, 0);
        push_read(129, 0);
        push_read(0, 255);

        wait_idle();
        repeat (20) @(posedge i_clk);
        $display("covered %0d pixels, %0d bin reads, %0d clears, %0d ignored ops, %0d settings",
                 n_pixels, n_reads, n_clears, n_ignored, n_settings);
        $display("checked %0d results, %0d mismatches", n_checked, n_errors);
        if (n_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #(100_000_000);
        $display("timeout with %0d results outstanding", bin_expect_q.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
